// ===== rtl/efd_pkg.sv =====
`timescale 1ns / 1ps

package efd_pkg;

   localparam int MAX_PAYLOAD_DEFAULT = 32;
   localparam int STORE_DEPTH = 10;

   localparam logic [7:0] HEAD1_BYTE  = 8'hAA;
   localparam logic [7:0] HEAD2_BYTE  = 8'h55;
   localparam logic [7:0] ESC_BYTE    = 8'hA5;
   localparam logic [7:0] ESC_CODE_AA = 8'h01;
   localparam logic [7:0] ESC_CODE_55 = 8'h02;
   localparam logic [7:0] ESC_CODE_A5 = 8'h03;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic        status;
      logic [7:0]  start_byte;
      logic [7:0]  direction_bits;
      logic [15:0] speed_m1;
      logic [15:0] speed_m2;
      logic [15:0] speed_m3;
      logic [15:0] speed_m4;
   } result_type;

endpackage

// ===== rtl/efd_parser.sv =====
`timescale 1ns / 1ps

module efd_parser
   import efd_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_valid,
   input  byte_type   rx_byte,
   output logic       result_valid,
   output result_type result
);

   localparam int CW = $clog2(MAX_PAYLOAD + 2);

   localparam logic [1:0] PH_HEAD1 = 2'd0;
   localparam logic [1:0] PH_HEAD2 = 2'd1;
   localparam logic [1:0] PH_LEN   = 2'd2;
   localparam logic [1:0] PH_DATA  = 2'd3;

   logic [1:0]    phase_ff, phase_in;
   byte_type      store_ff [STORE_DEPTH];
   byte_type      store_in [STORE_DEPTH];
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] target_ff, target_in;
   logic          esc_ff, esc_in;
   byte_type      sum_ff, sum_in;

   byte_type      data_byte;
   logic          data_ok;
   logic [CW-1:0] count_next;
   logic          done;

   assign count_next = count_ff + CW'(1);

   always_comb begin
      phase_in  = phase_ff;
      store_in  = store_ff;
      count_in  = count_ff;
      target_in = target_ff;
      esc_in    = esc_ff;
      sum_in    = sum_ff;
      data_byte = rx_byte;
      data_ok   = 1'b0;
      done      = 1'b0;
      if (byte_valid) begin
         case (phase_ff)
            PH_HEAD1: begin
               if (rx_byte == HEAD1_BYTE) phase_in = PH_HEAD2;
            end
            PH_HEAD2: begin
               if (rx_byte == HEAD2_BYTE) phase_in = PH_LEN;
               else if (rx_byte != HEAD1_BYTE) phase_in = PH_HEAD1;
            end
            PH_LEN: begin
               if (rx_byte == 8'd0 || {1'b0, rx_byte} > 9'(MAX_PAYLOAD)) begin
                  phase_in = PH_HEAD1;
               end else begin
                  target_in = CW'({1'b0, rx_byte} + 9'd1);
                  count_in  = '0;
                  esc_in    = 1'b0;
                  sum_in    = '0;
                  phase_in  = PH_DATA;
               end
            end
            default: begin
               if (esc_ff) begin
                  esc_in = 1'b0;
                  case (rx_byte)
                     ESC_CODE_AA: begin data_byte = HEAD1_BYTE; data_ok = 1'b1; end
                     ESC_CODE_55: begin data_byte = HEAD2_BYTE; data_ok = 1'b1; end
                     ESC_CODE_A5: begin data_byte = ESC_BYTE;   data_ok = 1'b1; end
                     default:     phase_in = PH_HEAD1;
                  endcase
               end else if (rx_byte == HEAD1_BYTE) begin
                  // bare header byte inside a frame: resync on the second header byte
                  phase_in = PH_HEAD2;
               end else if (rx_byte == ESC_BYTE) begin
                  esc_in = 1'b1;
               end else begin
                  data_ok = 1'b1;
               end
               if (data_ok) begin
                  if (count_ff < CW'(STORE_DEPTH)) store_in[count_ff[3:0]] = data_byte;
                  count_in = count_next;
                  if (count_next < target_ff) begin
                     sum_in = sum_ff + data_byte;
                  end else begin
                     done     = 1'b1;
                     phase_in = PH_HEAD1;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEAD1;
         count_ff  <= '0;
         target_ff <= '0;
         esc_ff    <= 1'b0;
         sum_ff    <= '0;
         for (int i = 0; i < STORE_DEPTH; i++) store_ff[i] <= '0;
      end else begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         target_ff <= target_in;
         esc_ff    <= esc_in;
         sum_ff    <= sum_in;
         store_ff  <= store_in;
      end
   end

   // fields come from the store as it stands after this byte is written
   always_comb begin
      result_valid = done;
      if (sum_ff != data_byte) begin
         result        = '0;
         result.status = 1'b1;
      end else begin
         result.status         = 1'b0;
         result.start_byte     = store_in[0];
         result.direction_bits = store_in[1];
         result.speed_m1       = {store_in[3], store_in[2]};
         result.speed_m2       = {store_in[5], store_in[4]};
         result.speed_m3       = {store_in[7], store_in[6]};
         result.speed_m4       = {store_in[9], store_in[8]};
      end
   end

endmodule

// ===== rtl/efd_out_reg.sv =====
`timescale 1ns / 1ps

module efd_out_reg
   import efd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   output logic       can_take,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign can_take  = !valid_ff || out_ready;
   assign valid_in  = load ? 1'b1 : (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= load_data;
   end

endmodule

// ===== rtl/escaped_frame_deframer_core.sv =====
`timescale 1ns / 1ps

// channel | ports                        | direction
// --------+------------------------------+----------
// req     | req_valid req_ready req_rx_byte | in
// rsp     | rsp_valid rsp_ready rsp_status rsp_start_byte
//         | rsp_direction_bits rsp_speed_m1..rsp_speed_m4 | out
//
// one byte per cycle sustained while no held result stalls the parser; a byte is held
// in the input register, and the parser updates its state and loads the result register
// as it takes that byte, so a frame result is registered behind its checksum byte.
// reset clears the parser state and the ten byte store at once.
// a held result stalls the parser only while it is not taken; rsp_ready low backs up
// through the input register to req_ready.

module escaped_frame_deframer_core
   import efd_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic [7:0]  rsp_start_byte,
   output logic [7:0]  rsp_direction_bits,
   output logic [15:0] rsp_speed_m1,
   output logic [15:0] rsp_speed_m2,
   output logic [15:0] rsp_speed_m3,
   output logic [15:0] rsp_speed_m4
);

   logic       in_valid_ff, in_valid_in;
   byte_type   in_byte_ff;
   logic       advance;
   logic       can_take;
   logic       res_valid;
   result_type res_data;
   result_type out_data;

   assign advance     = in_valid_ff && can_take;
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_byte_ff <= req_rx_byte;
   end

   efd_parser #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (advance),
      .rx_byte     (in_byte_ff),
      .result_valid(res_valid),
      .result      (res_data)
   );

   efd_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (res_valid),
      .load_data(res_data),
      .can_take (can_take),
      .out_valid(rsp_valid),
      .out_ready(rsp_ready),
      .out_data (out_data)
   );

   assign rsp_status         = out_data.status;
   assign rsp_start_byte     = out_data.start_byte;
   assign rsp_direction_bits = out_data.direction_bits;
   assign rsp_speed_m1       = out_data.speed_m1;
   assign rsp_speed_m2       = out_data.speed_m2;
   assign rsp_speed_m3       = out_data.speed_m3;
   assign rsp_speed_m4       = out_data.speed_m4;

endmodule
